// ===== sv/kde_pkg.sv =====
// Shared constants, the state type and a helper function for the keypad decimal entry core.
package kde_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int KEY_W      = 5;
    localparam int BCD_DIGITS = 16;
    localparam int BCD_W      = 64;
    localparam int BIN_W      = 54;
    localparam int LEN_W      = 6;
    localparam int TENS_W     = 3;
    localparam int ONES_W     = 4;
    localparam int CHUNK_W    = 8;
    localparam int POS_W      = 3;
    localparam int LEN_FULL_W = 7;

    localparam logic [KEY_W-1:0] KEY_NONE   = 5'd16;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd15;
    localparam logic [KEY_W-1:0] KEY_DIGITS = 5'd10;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } kde_state_t;

    function automatic int value_bits(input int n);
        logic [63:0] p;
        int          b;
        p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        p = p - 64'd1;
        b = 1;
        for (int i = 0; i < 64; i++)
        begin
            if (p[i])
            begin
                b = i + 1;
            end
        end
        return b;
    endfunction

endpackage

// ===== sv/keypad_decimal_entry_bit_length_core.sv =====
// Top level of the keypad decimal entry core with binary value and bit-length readout.
//
// Each beat on the input is one scan of a 16-key pad. A key whose bit rises against the
// previous scan counts as pressed, the highest such index winning; digit keys shift into
// a NUM_DIGITS-digit decimal register and key 15 clears it. One result beat follows each
// scan. A single shift-and-add unit multiplies the running value by ten, one digit a cycle,
// and a leading-one search then inspects one byte of the value a cycle, from the top byte
// down. The input stalls until the result is taken into the output register; a finished
// result may wait on the output while the next scan is taken.
module keypad_decimal_entry_bit_length_core #(
    parameter int NUM_DIGITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [kde_pkg::NUM_KEYS-1:0] key_states,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kde_pkg::KEY_W-1:0]    key_seen,
    output logic [kde_pkg::BCD_W-1:0]    digits_bcd,
    output logic [kde_pkg::BIN_W-1:0]    binary_value,
    output logic [kde_pkg::LEN_W-1:0]    bit_length,
    output logic [kde_pkg::TENS_W-1:0]   length_tens,
    output logic [kde_pkg::ONES_W-1:0]   length_ones
);
    import kde_pkg::*;

    localparam int VAL_W   = value_bits(NUM_DIGITS);
    localparam int CH_N    = (VAL_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W   = CH_N * CHUNK_W;
    localparam int CH_W    = (CH_N > 1) ? $clog2(CH_N) : 1;
    localparam int DIG_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int BCD_N   = (NUM_DIGITS < BCD_DIGITS) ? NUM_DIGITS : BCD_DIGITS;

    kde_state_t              state_reg, state_next;
    logic [NUM_KEYS-1:0]     prev_reg;
    logic [3:0]              digit_reg [NUM_DIGITS];
    logic [KEY_W-1:0]        key_reg;
    logic [VAL_W-1:0]        acc_reg, acc_next;
    logic [DIG_W-1:0]        dig_idx_reg;
    logic [CH_W-1:0]         ch_idx_reg;
    logic [LEN_FULL_W-1:0]   len_reg, len_next;

    logic                    out_valid_reg;
    logic [KEY_W-1:0]        key_out_reg;
    logic [BCD_W-1:0]        bcd_out_reg;
    logic [BIN_W-1:0]        bin_out_reg;
    logic [LEN_W-1:0]        len_out_reg;
    logic [TENS_W-1:0]       tens_out_reg;
    logic [ONES_W-1:0]       ones_out_reg;

    logic                    in_accept;
    logic                    out_free;
    logic [NUM_KEYS-1:0]     fresh;
    logic [KEY_W-1:0]        key_found;
    logic [PAD_W-1:0]        val_pad;
    logic [CHUNK_W-1:0]      chunk;
    logic [POS_W-1:0]        chunk_pos;
    logic [BCD_W-1:0]        bcd_now;
    logic [LEN_W-1:0]        len6;
    logic [13:0]             tens_prod;
    logic [TENS_W-1:0]       tens_now;
    logic [ONES_W-1:0]       ones_now;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        fresh     = key_states & ~prev_reg;
        key_found = KEY_NONE;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (fresh[i])
            begin
                key_found = KEY_W'(i);
            end
        end
    end

    // shared shift-and-add: value * 10 + digit
    assign acc_next = (acc_reg << 3) + (acc_reg << 1) + VAL_W'(digit_reg[dig_idx_reg]);

    assign val_pad = PAD_W'(acc_reg);
    assign chunk   = val_pad[ch_idx_reg * CHUNK_W +: CHUNK_W];

    always_comb
    begin
        chunk_pos = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            if (chunk[i])
            begin
                chunk_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (dig_idx_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chunk != '0)
                begin
                    len_next   = LEN_FULL_W'({ch_idx_reg, 3'b000}) + LEN_FULL_W'(chunk_pos)
                                 + LEN_FULL_W'(1);
                    state_next = ST_DONE;
                end
                else if (ch_idx_reg == '0)
                begin
                    len_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bcd_now = '0;
        for (int i = 0; i < BCD_N; i++)
        begin
            bcd_now[i*4 +: 4] = digit_reg[i];
        end
    end

    assign len6      = len_reg[LEN_W-1:0];
    assign tens_prod = 14'(len6) * 14'd205;
    assign tens_now  = tens_prod[13:11];
    assign ones_now  = ONES_W'(len6 - LEN_W'(tens_now) * LEN_W'(10));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                prev_reg <= key_states;
                if (key_found < KEY_DIGITS)
                begin
                    for (int i = NUM_DIGITS - 1; i > 0; i--)
                    begin
                        digit_reg[i] <= digit_reg[i-1];
                    end
                    digit_reg[0] <= key_found[3:0];
                end
                else if (key_found == KEY_CLEAR)
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        digit_reg[i] <= '0;
                    end
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (in_accept)
        begin
            key_reg     <= key_found;
            acc_reg     <= '0;
            dig_idx_reg <= DIG_W'(NUM_DIGITS - 1);
        end
        if (state_reg == ST_MAC)
        begin
            acc_reg     <= acc_next;
            dig_idx_reg <= dig_idx_reg - DIG_W'(1);
            ch_idx_reg  <= CH_W'(CH_N - 1);
        end
        if (state_reg == ST_SCAN)
        begin
            ch_idx_reg <= ch_idx_reg - CH_W'(1);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            key_out_reg  <= key_reg;
            bcd_out_reg  <= bcd_now;
            bin_out_reg  <= BIN_W'(acc_reg);
            len_out_reg  <= len6;
            tens_out_reg <= tens_now;
            ones_out_reg <= ones_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_seen     = key_out_reg;
    assign digits_bcd   = bcd_out_reg;
    assign binary_value = bin_out_reg;
    assign bit_length   = len_out_reg;
    assign length_tens  = tens_out_reg;
    assign length_ones  = ones_out_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the keypad decimal entry core: scan stimulus, readout prediction and checking.
module tb;

    localparam int DIGITS = 16;

    typedef struct {
        logic [kde_pkg::KEY_W-1:0]  key;
        logic [kde_pkg::BCD_W-1:0]  bcd;
        logic [kde_pkg::BIN_W-1:0]  value;
        logic [kde_pkg::LEN_W-1:0]  len;
        logic [kde_pkg::TENS_W-1:0] tens;
        logic [kde_pkg::ONES_W-1:0] ones;
    } readout_t;

    localparam logic [15:0] OPENING_SCANS [23] = '{
        16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0004, 16'h0008,
        16'h0010, 16'h0020, 16'h0040, 16'h0080, 16'h0100, 16'h0200, 16'h0400, 16'h0800,
        16'h1000, 16'h2000, 16'h4000, 16'h8000, 16'h03FF, 16'h7FFF, 16'h0000
    };
    localparam int SEND_PLAN [4] = '{0, 83, 0, 10};
    localparam int RECV_PLAN [4] = '{0, 0, 83, 10};

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              out_stall  = 1'b0;
    logic [kde_pkg::NUM_KEYS-1:0]      key_states = '0;
    logic                              in_stall;
    logic                              out_valid;
    logic [kde_pkg::KEY_W-1:0]         key_seen;
    logic [kde_pkg::BCD_W-1:0]         digits_bcd;
    logic [kde_pkg::BIN_W-1:0]         binary_value;
    logic [kde_pkg::LEN_W-1:0]         bit_length;
    logic [kde_pkg::TENS_W-1:0]        length_tens;
    logic [kde_pkg::ONES_W-1:0]        length_ones;

    logic [15:0]                       held_keys = '0;
    logic [3:0]                        entry_digits [DIGITS] = '{default: 4'd0};
    logic [15:0]                       scans_pending [$];
    readout_t                          readouts_due [$];
    int                                send_idle_pct  = 0;
    int                                recv_stall_pct = 0;
    int                                mismatches     = 0;

    keypad_decimal_entry_bit_length_core #(
        .NUM_DIGITS(DIGITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .key_states(key_states),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .key_seen(key_seen),
        .digits_bcd(digits_bcd),
        .binary_value(binary_value),
        .bit_length(bit_length),
        .length_tens(length_tens),
        .length_ones(length_ones)
    );

    function automatic readout_t scan_keypad(input logic [15:0] now);
        logic [15:0]                fresh;
        logic [kde_pkg::KEY_W-1:0]  key;
        logic [63:0]                acc;
        logic [63:0]                bcd;
        int                         len;
        logic [5:0]                 len6;
        readout_t                   r;
        fresh = now & ~held_keys;
        key   = kde_pkg::KEY_NONE;
        for (int i = 0; i < kde_pkg::NUM_KEYS; i++)
        begin
            if (fresh[i])
            begin
                key = 5'(i);
            end
        end
        held_keys = now;
        if (key < kde_pkg::KEY_DIGITS)
        begin
            for (int i = DIGITS - 1; i > 0; i--)
            begin
                entry_digits[i] = entry_digits[i-1];
            end
            entry_digits[0] = key[3:0];
        end
        else if (key == kde_pkg::KEY_CLEAR)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                entry_digits[i] = 4'd0;
            end
        end
        acc = '0;
        bcd = '0;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            acc = acc * 64'd10 + 64'(entry_digits[i]);
            bcd = {bcd[59:0], entry_digits[i]};
        end
        len = 0;
        for (int i = 1; i <= 64; i++)
        begin
            if (acc[i-1])
            begin
                len = i;
            end
        end
        len6    = len[5:0];
        r.key   = key;
        r.bcd   = bcd;
        r.value = acc[kde_pkg::BIN_W-1:0];
        r.len   = len6;
        r.tens  = 3'(len6 / 10);
        r.ones  = 4'(len6 % 10);
        return r;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %h got %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_typing(input int n);
        int          added;
        int          pick;
        int          run;
        logic [15:0] chord;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                scans_pending.push_back(16'h0000);
                scans_pending.push_back(16'(1) << $urandom_range(0, kde_pkg::KEY_DIGITS - 1));
                added += 2;
            end
            else if (pick < 55)
            begin
                run = $urandom_range(DIGITS, DIGITS + 3);
                repeat (run)
                begin
                    scans_pending.push_back(16'(1) << (kde_pkg::KEY_DIGITS - 1));
                    scans_pending.push_back(16'h0000);
                end
                added += 2 * run;
            end
            else if (pick < 62)
            begin
                scans_pending.push_back(16'(1) << kde_pkg::KEY_CLEAR);
                scans_pending.push_back(16'h0000);
                added += 2;
            end
            else if (pick < 70)
            begin
                scans_pending.push_back(16'(1) << $urandom_range(kde_pkg::KEY_DIGITS,
                                                                  kde_pkg::KEY_CLEAR - 1));
                added++;
            end
            else if (pick < 80)
            begin
                chord = 16'($urandom_range(0, 16'hFFFF));
                scans_pending.push_back(chord);
                scans_pending.push_back(chord | (16'(1) << $urandom_range(0, 15)));
                added += 2;
            end
            else
            begin
                scans_pending.push_back(16'($urandom_range(0, 16'hFFFF)));
                added++;
            end
        end
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // driver: hold a stalled beat, advance on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                readouts_due.push_back(scan_keypad(key_states));
            end
            if (!in_valid || !in_stall)
            begin
                if (scans_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    key_states <= scans_pending.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readouts_due.size() == 0)
                begin
                    $display("%0t unexpected beat expected none got key %h bcd %h", $time,
                             key_seen, digits_bcd);
                    mismatches++;
                end
                else
                begin
                    want = readouts_due.pop_front();
                    check_field("key_seen", 64'(want.key), 64'(key_seen));
                    check_field("digits_bcd", want.bcd, digits_bcd);
                    check_field("binary_value", 64'(want.value), 64'(binary_value));
                    check_field("bit_length", 64'(want.len), 64'(bit_length));
                    check_field("length_tens", 64'(want.tens), 64'(length_tens));
                    check_field("length_ones", 64'(want.ones), 64'(length_ones));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (OPENING_SCANS[i])
        begin
            scans_pending.push_back(OPENING_SCANS[i]);
        end
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = SEND_PLAN[p];
            recv_stall_pct = RECV_PLAN[p];
            queue_typing(460);
            // drain every outstanding readout before the next phase
            while (scans_pending.size() != 0 || in_valid || readouts_due.size() != 0)
            begin
                @(posedge clk);
            end
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
